[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRUKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRUKD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LRUKD_ASSERT(lbl, prop, msg)
`define LRUKD_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/lrukd_pkg.sv]
// types, codes and defaults of the keyed cache directory
`timescale 1ns / 1ps
package lrukd_pkg;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_PURGE   = 3'd2;
  localparam logic [2:0] OP_FLUSH   = 3'd3;
  localparam logic [2:0] OP_COMPACT = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;

  localparam logic [1:0] CFG_ENTRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_BYTE_BUDGET = 2'd1;
  localparam logic [1:0] CFG_EXPIRE_AGE  = 2'd2;

  localparam logic [4:0]  ENTRY_LIMIT_RST = 5'd16;
  localparam logic [31:0] BYTE_BUDGET_RST = 32'd262144;
  localparam logic [31:0] EXPIRE_AGE_RST  = 32'(60 * 60 * 1000);

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] family_key;
    logic signed [15:0] point_size;
    logic signed [15:0] style_bits;
    logic signed [15:0] device_key;
    logic [23:0]        data_bytes;
    logic [31:0]        time_now;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  hit_slot;
    logic [4:0]  evicted_count;
    logic [4:0]  entry_count;
    logic [31:0] total_bytes;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] family;
    logic [15:0] size;
    logic [15:0] style;
    logic [15:0] device;
    logic [23:0] bytes;
    logic [31:0] last_used;
    logic [31:0] order;
  } entry_t;
endpackage

[hw/rtl/lrukd_cell.sv]
// one directory entry in the rotating row of cells
`timescale 1ns / 1ps
module lrukd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clear,
  input  lrukd_pkg::entry_t din,
  output lrukd_pkg::entry_t dout
);
  lrukd_pkg::entry_t q;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (clear) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= din.valid;
    end
    if (shift) begin
      q.family    <= din.family;
      q.size      <= din.size;
      q.style     <= din.style;
      q.device    <= din.device;
      q.bytes     <= din.bytes;
      q.last_used <= din.last_used;
      q.order     <= din.order;
    end
  end

  assign dout = q;
endmodule

[hw/rtl/lru_keyed_cache_directory_top.sv]
// keyed cache directory with lru replacement, top level
// Entries sit in a ring of MAX_ENTRIES cells that rotates one place per cycle
// during a pass; a controller at the head examines or rewrites one entry per
// cycle, and the ring is back in place after each pass. Lookup makes a scan
// pass and an update pass, purge and compact one pass each, flush and unused
// codes go straight to the result; insert makes k+1 scan passes, where k is the
// number of entries evicted to make room for the bytes, then a placing pass.
// The result appears on result for one cycle with result_valid; it cannot be
// stalled. busy stays high from the accepted item until that result cycle
// ends. Configuration writes are always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_keyed_cache_directory_top #(
  parameter int MAX_ENTRIES = lrukd_pkg::MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lrukd_pkg::in_t   cmd,
  output logic             result_valid,
  output lrukd_pkg::out_t  result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LK_SCAN = 9'b000000010,
    S_LK_UPD  = 9'b000000100,
    S_IN_SCAN = 9'b000001000,
    S_IN_DEC  = 9'b000010000,
    S_IN_PLACE= 9'b000100000,
    S_PURGE   = 9'b001000000,
    S_COMPACT = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state, state_next;
  lrukd_pkg::in_t cmd_q, cmd_q_next;
  logic [IDX_W-1:0] idx, idx_next, best_idx, best_idx_next, victim, victim_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic found, found_next, drop_pend, drop_pend_next, placed, placed_next;
  logic cmp_en, cmp_en_next;
  logic [31:0] best_lu, best_lu_next, best_age, best_age_next;
  logic [31:0] limit_time, limit_time_next;
  logic [CNT_W-1:0] evicted, evicted_next, held_count, held_count_next;
  logic [1:0] status, status_next;
  logic [31:0] held_bytes, held_bytes_next, seq, seq_next;
  logic [31:0] hits, hits_next, misses, misses_next;
  logic [4:0] entry_limit;
  logic [31:0] byte_budget, expire_age;

  lrukd_pkg::entry_t cell_q [MAX_ENTRIES];
  lrukd_pkg::entry_t head, head_mod;
  logic shift_en, flush_clr, drop_now, place_now, is_last, key_eq;
  logic [31:0] age, eff_limit, slot_wide, evicted_wide, count_wide;
  logic [32:0] need_bytes;

  assign head     = cell_q[0];
  assign is_last  = (idx == LAST_IDX);
  assign age      = seq - head.order;
  assign key_eq   = head.family == cmd_q.family_key && head.size == cmd_q.point_size &&
                    head.style == cmd_q.style_bits && head.device == cmd_q.device_key;
  assign need_bytes = {1'b0, held_bytes} + {9'b0, cmd_q.data_bytes};

  always_comb begin
    eff_limit = 32'(entry_limit);
    if (eff_limit == 32'd0) begin
      eff_limit = 32'd1;
    end else if (eff_limit > 32'(MAX_ENTRIES)) begin
      eff_limit = 32'(MAX_ENTRIES);
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      if (k == MAX_ENTRIES - 1) begin : g_tail
        lrukd_cell u_cell (
          .clk(clk), .rst(rst), .shift(shift_en), .clear(flush_clr),
          .din(head_mod), .dout(cell_q[k])
        );
      end else begin : g_body
        lrukd_cell u_cell (
          .clk(clk), .rst(rst), .shift(shift_en), .clear(flush_clr),
          .din(cell_q[k+1]), .dout(cell_q[k])
        );
      end
    end
  endgenerate

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    idx_next        = idx;
    best_idx_next   = best_idx;
    victim_next     = victim;
    slot_next       = slot;
    found_next      = found;
    drop_pend_next  = drop_pend;
    placed_next     = placed;
    cmp_en_next     = cmp_en;
    best_lu_next    = best_lu;
    best_age_next   = best_age;
    limit_time_next = limit_time;
    evicted_next    = evicted;
    held_count_next = held_count;
    status_next     = status;
    held_bytes_next = held_bytes;
    seq_next        = seq;
    hits_next       = hits;
    misses_next     = misses;
    head_mod        = head;
    shift_en        = 1'b0;
    flush_clr       = 1'b0;
    drop_now        = 1'b0;
    place_now       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next      = cmd;
          idx_next        = '0;
          found_next      = 1'b0;
          drop_pend_next  = 1'b0;
          placed_next     = 1'b0;
          evicted_next    = '0;
          slot_next       = '0;
          status_next     = lrukd_pkg::ST_OK;
          cmp_en_next     = cmd.time_now >= expire_age;
          limit_time_next = cmd.time_now - expire_age;
          unique case (cmd.operation)
            lrukd_pkg::OP_LOOKUP:  state_next = S_LK_SCAN;
            lrukd_pkg::OP_INSERT:  state_next = S_IN_SCAN;
            lrukd_pkg::OP_PURGE:   state_next = S_PURGE;
            lrukd_pkg::OP_COMPACT: state_next = S_COMPACT;
            lrukd_pkg::OP_FLUSH: begin
              flush_clr       = 1'b1;
              evicted_next    = held_count;
              held_count_next = '0;
              held_bytes_next = '0;
              state_next      = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_LK_SCAN: begin
        shift_en = 1'b1;
        if (head.valid && key_eq && (!found || age < best_age)) begin
          found_next    = 1'b1;
          best_idx_next = idx;
          best_age_next = age;
        end
        if (is_last) begin
          state_next = S_LK_UPD;
        end
      end
      S_LK_UPD: begin
        shift_en = 1'b1;
        if (found && idx == best_idx) begin
          head_mod.last_used = cmd_q.time_now;
        end
        if (is_last) begin
          if (found) begin
            hits_next = hits + 32'd1;
            slot_next = best_idx;
          end else begin
            misses_next = misses + 32'd1;
            status_next = lrukd_pkg::ST_MISS;
          end
          state_next = S_DONE;
        end
      end
      S_IN_SCAN: begin
        shift_en = 1'b1;
        if (drop_pend && idx == victim) begin
          drop_now = 1'b1;
        end else if (head.valid && (!found || head.last_used < best_lu ||
                     (head.last_used == best_lu && age < best_age))) begin
          found_next    = 1'b1;
          best_idx_next = idx;
          best_lu_next  = head.last_used;
          best_age_next = age;
        end
        if (is_last) begin
          state_next = S_IN_DEC;
        end
      end
      S_IN_DEC: begin
        found_next = 1'b0;
        idx_next   = '0;
        if (need_bytes > {1'b0, byte_budget}) begin
          if (held_count != '0) begin
            victim_next    = best_idx;
            drop_pend_next = 1'b1;
            evicted_next   = evicted + CNT_W'(1);
            state_next     = S_IN_SCAN;
          end else begin
            status_next = lrukd_pkg::ST_REFUSE;
            state_next  = S_DONE;
          end
        end else begin
          if (32'(held_count) >= eff_limit) begin
            victim_next    = best_idx;
            drop_pend_next = 1'b1;
            evicted_next   = evicted + CNT_W'(1);
          end else begin
            drop_pend_next = 1'b0;
          end
          state_next = S_IN_PLACE;
        end
      end
      S_IN_PLACE: begin
        shift_en = 1'b1;
        drop_now = drop_pend && idx == victim;
        if ((!head.valid || drop_now) && !placed) begin
          place_now   = 1'b1;
          placed_next = 1'b1;
          slot_next   = idx;
          seq_next    = seq + 32'd1;
        end
        if (is_last) begin
          if (!placed_next) begin
            status_next = lrukd_pkg::ST_REFUSE;
          end
          state_next = S_DONE;
        end
      end
      S_PURGE: begin
        shift_en = 1'b1;
        drop_now = head.valid && head.family == cmd_q.family_key;
        if (drop_now) begin
          evicted_next = evicted + CNT_W'(1);
        end
        if (is_last) begin
          state_next = S_DONE;
        end
      end
      S_COMPACT: begin
        shift_en = 1'b1;
        drop_now = cmp_en && head.valid && head.last_used < limit_time;
        if (drop_now) begin
          evicted_next = evicted + CNT_W'(1);
        end
        if (is_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (shift_en) begin
      idx_next = is_last ? '0 : idx + IDX_W'(1);
    end
    if (drop_now) begin
      head_mod.valid = 1'b0;
    end
    if (place_now) begin
      head_mod.valid     = 1'b1;
      head_mod.family    = cmd_q.family_key;
      head_mod.size      = cmd_q.point_size;
      head_mod.style     = cmd_q.style_bits;
      head_mod.device    = cmd_q.device_key;
      head_mod.bytes     = cmd_q.data_bytes;
      head_mod.last_used = cmd_q.time_now;
      head_mod.order     = seq + 32'd1;
    end
    if (drop_now || place_now) begin
      held_count_next = held_count - CNT_W'(drop_now) + CNT_W'(place_now);
      held_bytes_next = held_bytes - (drop_now ? {8'b0, head.bytes} : 32'd0)
                        + (place_now ? {8'b0, cmd_q.data_bytes} : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      held_bytes <= '0;
      seq        <= '0;
      hits       <= '0;
      misses     <= '0;
      found      <= 1'b0;
      drop_pend  <= 1'b0;
      placed     <= 1'b0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      held_bytes <= held_bytes_next;
      seq        <= seq_next;
      hits       <= hits_next;
      misses     <= misses_next;
      found      <= found_next;
      drop_pend  <= drop_pend_next;
      placed     <= placed_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    best_idx   <= best_idx_next;
    victim     <= victim_next;
    slot       <= slot_next;
    cmp_en     <= cmp_en_next;
    best_lu    <= best_lu_next;
    best_age   <= best_age_next;
    limit_time <= limit_time_next;
    evicted    <= evicted_next;
    status     <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= lrukd_pkg::ENTRY_LIMIT_RST;
      byte_budget <= lrukd_pkg::BYTE_BUDGET_RST;
      expire_age  <= lrukd_pkg::EXPIRE_AGE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrukd_pkg::CFG_ENTRY_LIMIT: entry_limit <= cfg_data[4:0];
        lrukd_pkg::CFG_BYTE_BUDGET: byte_budget <= cfg_data;
        lrukd_pkg::CFG_EXPIRE_AGE:  expire_age  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready    = 1'b1;
  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);
  assign slot_wide    = 32'(slot);
  assign evicted_wide = 32'(evicted);
  assign count_wide   = 32'(held_count);

  always_comb begin
    result.status        = status;
    result.hit_slot      = slot_wide[3:0];
    result.evicted_count = evicted_wide[4:0];
    result.entry_count   = count_wide[4:0];
    result.total_bytes   = held_bytes;
    result.hit_total     = hits;
    result.miss_total    = misses;
  end

  `LRUKD_ASSERT(a_count_range, held_count <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
  `LRUKD_ASSERT(a_done_to_idle, result_valid |=> !busy, "busy after result")
  `LRUKD_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not start")
  `LRUKD_ASSERT(a_status_code, result_valid |-> (status == lrukd_pkg::ST_OK || status == lrukd_pkg::ST_MISS || status == lrukd_pkg::ST_REFUSE), "bad status")
  `LRUKD_NEVER(a_refuse_placed, result_valid && placed && status == lrukd_pkg::ST_REFUSE, "placed item refused")
endmodule
